FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the checker file.
// CRS_ASSERT is disabled while reset is low; CRS_ASSERT_ALWAYS also
// samples during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define CRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: rtl/core/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg: spline evaluator shared types and constants
// Fixed-point formats, internal widths and the payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

package crs_pkg;

    // Control values and result, signed with 16 fraction bits
    localparam int POINT_WIDTH   = 32;
    // Position and tension, unsigned Q1.15
    localparam int POS_WIDTH     = 16;
    localparam int TENSION_WIDTH = 16;
    localparam int FRAC_SHIFT    = 15;
    localparam int ROUND_SHIFT   = 4 * FRAC_SHIFT;

    localparam logic [TENSION_WIDTH-1:0] TENSION_RESET = 16'd16384;

    // Coefficient widths (scaled by 2^15)
    localparam int C2_W = POINT_WIDTH + 18;
    localparam int C3_W = POINT_WIDTH + 21;
    localparam int C4_W = POINT_WIDTH + 20;

    // Horner accumulator widths, exact for any input
    localparam int ACC1_W = POINT_WIDTH + 38;
    localparam int ACC2_W = POINT_WIDTH + 56;
    localparam int ACC3_W = POINT_WIDTH + 74;

    localparam logic signed [POINT_WIDTH-1:0] POINT_MAX = {1'b0, {(POINT_WIDTH-1){1'b1}}};
    localparam logic signed [POINT_WIDTH-1:0] POINT_MIN = {1'b1, {(POINT_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic        [POS_WIDTH-1:0]   curve_pos;
        logic signed [POINT_WIDTH-1:0] point_before;
        logic signed [POINT_WIDTH-1:0] point_start;
        logic signed [POINT_WIDTH-1:0] point_end;
        logic signed [POINT_WIDTH-1:0] point_after;
    } crs_in_t;

    typedef struct packed {
        logic signed [POINT_WIDTH-1:0] curve_value;
        logic                          saturated;
    } crs_out_t;

    typedef struct packed {
        logic        [POS_WIDTH-1:0]   u;
        logic signed [POINT_WIDTH-1:0] p1;
        logic signed [C2_W-1:0]        c2;
        logic signed [C3_W-1:0]        c3;
        logic signed [C4_W-1:0]        c4;
    } crs_coef_t;

endpackage

`default_nettype wire

FILE: rtl/core/crs_coef.sv
// ----------------------------------------------------------------------------
// crs_coef: cubic coefficient pipeline
// Three stages: control value differences, tension products, final sums.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_coef (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  crs_pkg::crs_in_t                  in_item,
    input  logic [crs_pkg::TENSION_WIDTH-1:0] tension,
    output logic                              coef_valid,
    output crs_pkg::crs_coef_t                coef
);
    import crs_pkg::*;

    localparam int PW   = POINT_WIDTH;
    localparam int X_W  = PW + 3;
    localparam int D2_W = PW + 1;
    localparam int D3_W = PW + 3;
    localparam int D4_W = PW + 2;
    localparam int E3_W = PW + 3;
    localparam int E4_W = PW + 1;
    localparam int M2_W = C2_W;
    localparam int M3_W = PW + 20;
    localparam int M4_W = PW + 19;

    // Stage 1 signals
    logic signed [X_W-1:0]  x0, x1, x2, x3;
    logic signed [D2_W-1:0] d2_next, d2_reg;
    logic signed [D3_W-1:0] d3_next, d3_reg;
    logic signed [D4_W-1:0] d4_next, d4_reg;
    logic signed [E3_W-1:0] e3_next, e3_reg1;
    logic signed [E4_W-1:0] e4_next, e4_reg1;
    logic signed [X_W-1:0]  sub21;
    logic [TENSION_WIDTH-1:0] t_reg;
    logic [POS_WIDTH-1:0]     u_reg1, u_reg2, u_reg3;
    logic signed [PW-1:0]     p1_reg1, p1_reg2, p1_reg3;
    logic                     v1_reg, v2_reg, v3_reg;

    // Stage 2 signals
    logic signed [M2_W-1:0] m2_next, m2_reg;
    logic signed [M3_W-1:0] m3_next, m3_reg;
    logic signed [M4_W-1:0] m4_next, m4_reg;
    logic signed [E3_W-1:0] e3_reg2;
    logic signed [E4_W-1:0] e4_reg2;

    // Stage 3 signals
    logic signed [C2_W-1:0] c2_reg;
    logic signed [C3_W-1:0] c3_next, c3_reg;
    logic signed [C4_W-1:0] c4_next, c4_reg;

    // Stage 1: differences of control values
    always_comb
    begin
        x0      = X_W'(in_item.point_before);
        x1      = X_W'(in_item.point_start);
        x2      = X_W'(in_item.point_end);
        x3      = X_W'(in_item.point_after);
        sub21   = x2 - x1;
        d2_next = D2_W'(x2 - x0);
        d3_next = D3_W'((x0 <<< 1) + x1 - (x2 <<< 1) - x3);
        d4_next = D4_W'(x2 + x3 - x0 - x1);
        e3_next = E3_W'((sub21 <<< 1) + sub21);
        e4_next = E4_W'(x1 - x2);
    end

    // Stage 2: tension products
    always_comb
    begin
        m2_next = M2_W'(d2_reg) * M2_W'($signed({1'b0, t_reg}));
        m3_next = M3_W'(d3_reg) * M3_W'($signed({1'b0, t_reg}));
        m4_next = M4_W'(d4_reg) * M4_W'($signed({1'b0, t_reg}));
    end

    // Stage 3: add the fixed parts
    always_comb
    begin
        c3_next = C3_W'(m3_reg) + (C3_W'(e3_reg2) <<< FRAC_SHIFT);
        c4_next = C4_W'(m4_reg) + (C4_W'(e4_reg2) <<< (FRAC_SHIFT + 1));
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        d2_reg  <= d2_next;
        d3_reg  <= d3_next;
        d4_reg  <= d4_next;
        e3_reg1 <= e3_next;
        e4_reg1 <= e4_next;
        t_reg   <= tension;
        u_reg1  <= in_item.curve_pos;
        p1_reg1 <= in_item.point_start;

        m2_reg  <= m2_next;
        m3_reg  <= m3_next;
        m4_reg  <= m4_next;
        e3_reg2 <= e3_reg1;
        e4_reg2 <= e4_reg1;
        u_reg2  <= u_reg1;
        p1_reg2 <= p1_reg1;

        c2_reg  <= m2_reg;
        c3_reg  <= c3_next;
        c4_reg  <= c4_next;
        u_reg3  <= u_reg2;
        p1_reg3 <= p1_reg2;
    end

    assign coef_valid = v3_reg;
    assign coef.u     = u_reg3;
    assign coef.p1    = p1_reg3;
    assign coef.c2    = c2_reg;
    assign coef.c3    = c3_reg;
    assign coef.c4    = c4_reg;

endmodule

`default_nettype wire

FILE: rtl/core/crs_horner_step.sv
// ----------------------------------------------------------------------------
// crs_horner_step: one Horner step, acc * u + (c << SHIFT)
// Stage a forms split partial products, stage b aligns and adds them.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_horner_step #(
    parameter int A_W   = 52,
    parameter int C_W   = 53,
    parameter int SHIFT = 15,
    parameter int O_W   = 70
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic signed [A_W-1:0]         acc_in,
    input  logic signed [C_W-1:0]         c_in,
    input  logic [crs_pkg::POS_WIDTH-1:0] u_in,
    output logic                          valid_out,
    output logic signed [O_W-1:0]         acc_out
);
    import crs_pkg::*;

    localparam int LO_W = A_W / 2;
    localparam int HI_W = A_W - LO_W;
    localparam int PL_W = LO_W + POS_WIDTH;
    localparam int PH_W = HI_W + POS_WIDTH + 1;

    logic [PL_W-1:0]        plo_next, plo_reg;
    logic signed [PH_W-1:0] phi_next, phi_reg;
    logic signed [C_W-1:0]  c_reg;
    logic signed [O_W-1:0]  acc_next, acc_reg;
    logic                   va_reg, vb_reg;

    // Stage a: low half unsigned, high half signed
    always_comb
    begin
        plo_next = PL_W'(acc_in[LO_W-1:0]) * PL_W'(u_in);
        phi_next = PH_W'($signed(acc_in[A_W-1:LO_W])) * PH_W'($signed({1'b0, u_in}));
    end

    // Stage b: recombine and add the aligned coefficient
    always_comb
    begin
        acc_next = (O_W'(phi_reg) <<< LO_W) + O_W'(plo_reg) + (O_W'(c_reg) <<< SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= valid_in;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        c_reg   <= c_in;
        acc_reg <= acc_next;
    end

    assign valid_out = vb_reg;
    assign acc_out   = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/crs_round_sat.sv
// ----------------------------------------------------------------------------
// crs_round_sat: round to 16 fraction bits and saturate
// Adds half an LSB, drops the fraction, clips to the point range.
// ----------------------------------------------------------------------------
`default_nettype none

module crs_round_sat (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [crs_pkg::ACC3_W-1:0] acc,
    output logic                              done,
    output crs_pkg::crs_out_t                 result
);
    import crs_pkg::*;

    localparam int S_W    = ACC3_W + 1;
    localparam int R_W    = S_W - ROUND_SHIFT;
    localparam int PW_TOP = POINT_WIDTH - 1;
    localparam logic [S_W-1:0] HALF = S_W'(1) << (ROUND_SHIFT - 1);

    logic [S_W-1:0]        sum;
    logic [R_W-1:0]        rounded;
    logic [R_W-PW_TOP-1:0] top_bits;
    logic                  in_range;
    crs_out_t              result_next, result_reg;
    logic                  done_reg;

    // Round half up, then range check on the sign bit and the bits above it
    always_comb
    begin
        sum      = S_W'(acc) + HALF;
        rounded  = sum[S_W-1:ROUND_SHIFT];
        top_bits = rounded[R_W-1:PW_TOP];
        in_range = (&top_bits) | ~(|top_bits);
        if (in_range)
        begin
            result_next.curve_value = $signed(rounded[POINT_WIDTH-1:0]);
            result_next.saturated   = 1'b0;
        end
        else
        begin
            result_next.curve_value = rounded[R_W-1] ? POINT_MIN : POINT_MAX;
            result_next.saturated   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/core/catmull_rom_spline_eval_top.sv
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_top: Catmull-Rom segment evaluator with tension
// Coefficient pipeline, three Horner steps and a round/saturate stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive sample and raise start; a transfer happens at each
//   rising edge with start high and busy low. busy is always low, so one
//   sample may be transferred every cycle (throughput 1 item per cycle).
//   Output channel: done is high for one cycle with result valid; the result
//   is taken at the edge that ends that cycle. The receiver cannot stall.
//   Pipeline: a transferred sample passes through three coefficient stages,
//   two stages per Horner step for its split multiplier and one rounding
//   stage before its result is on the ports.
//   Tension: cfg_we writes cfg_wdata to the tension register; write it only
//   while no item is in flight.
//   Reset: rst_n low clears all valid bits at once and sets tension to 0.5;
//   items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_spline_eval_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  crs_pkg::crs_in_t                  sample,
    output logic                              done,
    output crs_pkg::crs_out_t                 result,
    input  logic                              cfg_we,
    input  logic [crs_pkg::TENSION_WIDTH-1:0] cfg_wdata
);
    import crs_pkg::*;

    logic [TENSION_WIDTH-1:0] tension_reg;
    logic                     accept;
    logic                     coef_valid;
    crs_coef_t                coef;

    logic                      v1, v2, v3;
    logic signed [ACC1_W-1:0]  acc1;
    logic signed [ACC2_W-1:0]  acc2;
    logic signed [ACC3_W-1:0]  acc3;

    // Side data lined up with the Horner steps
    logic [POS_WIDTH-1:0]          u_dly_reg  [4];
    logic signed [C2_W-1:0]        c2_dly_reg [2];
    logic signed [POINT_WIDTH-1:0] p1_dly_reg [4];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Tension register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tension_reg <= TENSION_RESET;
        else if (cfg_we)
            tension_reg <= cfg_wdata;
    end

    crs_coef u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .in_item    (sample),
        .tension    (tension_reg),
        .coef_valid (coef_valid),
        .coef       (coef)
    );

    // Delay lines for u, c2 and p1
    always_ff @(posedge clk)
    begin
        u_dly_reg[0]  <= coef.u;
        u_dly_reg[1]  <= u_dly_reg[0];
        u_dly_reg[2]  <= u_dly_reg[1];
        u_dly_reg[3]  <= u_dly_reg[2];
        c2_dly_reg[0] <= coef.c2;
        c2_dly_reg[1] <= c2_dly_reg[0];
        p1_dly_reg[0] <= coef.p1;
        p1_dly_reg[1] <= p1_dly_reg[0];
        p1_dly_reg[2] <= p1_dly_reg[1];
        p1_dly_reg[3] <= p1_dly_reg[2];
    end

    // acc1 = c4*u + c3*2^15
    crs_horner_step #(
        .A_W   (C4_W),
        .C_W   (C3_W),
        .SHIFT (FRAC_SHIFT),
        .O_W   (ACC1_W)
    ) u_step1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (coef_valid),
        .acc_in    (coef.c4),
        .c_in      (coef.c3),
        .u_in      (coef.u),
        .valid_out (v1),
        .acc_out   (acc1)
    );

    // acc2 = acc1*u + c2*2^30
    crs_horner_step #(
        .A_W   (ACC1_W),
        .C_W   (C2_W),
        .SHIFT (2 * FRAC_SHIFT),
        .O_W   (ACC2_W)
    ) u_step2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v1),
        .acc_in    (acc1),
        .c_in      (c2_dly_reg[1]),
        .u_in      (u_dly_reg[1]),
        .valid_out (v2),
        .acc_out   (acc2)
    );

    // acc3 = acc2*u + p1*2^60
    crs_horner_step #(
        .A_W   (ACC2_W),
        .C_W   (POINT_WIDTH),
        .SHIFT (ROUND_SHIFT),
        .O_W   (ACC3_W)
    ) u_step3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (v2),
        .acc_in    (acc2),
        .c_in      (p1_dly_reg[3]),
        .u_in      (u_dly_reg[3]),
        .valid_out (v3),
        .acc_out   (acc3)
    );

    crs_round_sat u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (v3),
        .acc      (acc3),
        .done     (done),
        .result   (result)
    );

endmodule

`default_nettype wire

FILE: rtl/core/crs_checker.sv
// ----------------------------------------------------------------------------
// crs_checker: port-level checks for the spline evaluator
// Latency, strobe origin, saturation values and reset behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module crs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input crs_pkg::crs_out_t result
);
    import crs_pkg::*;

    logic at_limit;

    // Result sits on one of the range rails
    assign at_limit = (result.curve_value == POINT_MAX) || (result.curve_value == POINT_MIN);

    // Every transfer is followed by its result strobe
    `CRS_ASSERT(a_latency, (start && !busy) |-> ##10 done, "result missing after transfer")

    // No result strobe without a matching earlier transfer
    `CRS_ASSERT(a_origin, done |-> $past(start && !busy, 10), "result without transfer")

    // A clipped result sits at one of the range limits
    `CRS_ASSERT(a_sat_value, (done && result.saturated) |-> at_limit, "saturated value off limit")

    // No strobe while reset is held
    `CRS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !done, "result during reset")

endmodule

bind catmull_rom_spline_eval_top crs_checker u_crs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire
